[hdl/dictionary_token_expander_macros.svh]
// assertion macros for the dictionary token expander checker
// no dependencies; included by the checker file only
`ifndef DICTIONARY_TOKEN_EXPANDER_MACROS_SVH
`define DICTIONARY_TOKEN_EXPANDER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define DTE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/dte_pkg.sv]
// shared types and constants of the dictionary token expander
// no dependencies
`timescale 1ns / 1ps

package dte_pkg;

	localparam int TABLE_WORDS_DEF = 128;
	localparam int WORD_CHARS_DEF  = 32;
	localparam int LEN_W           = 6;
	localparam int ACC_W           = 8;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef enum logic [1:0] {
		MODE_PLAIN    = 2'd0,
		MODE_DOLLAR   = 2'd1,
		MODE_DIGITS   = 2'd2,
		MODE_OVERFLOW = 2'd3
	} mode_t;

	// what one result slot of a stream beat produces
	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_DOLLAR = 2'd1,
		KIND_BYTE   = 2'd2,
		KIND_WORD   = 2'd3
	} kind_t;

	typedef struct packed {
		logic       cmd;
		logic [6:0] entry_index;
		logic [4:0] char_position;
		logic [7:0] data_byte;
		logic       word_end;
		logic       stream_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       bad_reference;
		logic       last_in_run;
	} out_item_t;

	// result plan of one stream beat, slots packed from index 0
	typedef struct packed {
		kind_t [2:0]      kinds;
		logic [1:0]       count;
		logic             has_word;
		logic [ACC_W-1:0] word_idx;
		logic             word_ovf;
	} plan_t;

endpackage

[hdl/dte_stream_if.sv]
// valid/ready channel carrying one payload struct per beat
// payload type comes from dte_pkg at instantiation
`timescale 1ns / 1ps

interface dte_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

[hdl/dictionary_token_expander.sv]
// Dictionary token expander.
// Channel items (sink): cmd 0 writes one character of a table word at
// entry_index / char_position; word_end also sets the word length. cmd 1 is
// a stream byte; "$" followed by decimal digits is replaced by the stored
// word, a lone "$" passes as is, stream_end flushes a pending token.
// Channel results (source): out_byte, bad_reference, last_in_run per beat.
// A single plain result stands in the output register in the cycle after
// the beat that causes it. Table writes and beats with at most one plain
// result leave the sequencer idle, so plain bytes flow at one per cycle
// while the receiver is ready. A beat that expands a word first passes the
// length memory read state; results of multi-result beats are then emitted
// slot by slot, a word one character per cycle from the character memory.
// Input is held off while a beat's results are still being produced.
// A stalled receiver freezes the output register and the character sequencer.
// Reset clears the scan state and the loaded flag of every table word; the
// character and length memories are not cleared.
// depends on dte_pkg, dte_stream_if, dte_ram, dte_scanner
`timescale 1ns / 1ps

module dictionary_token_expander #(
	parameter int TABLE_WORDS = dte_pkg::TABLE_WORDS_DEF,
	parameter int WORD_CHARS  = dte_pkg::WORD_CHARS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	dte_stream_if.sink    items,
	dte_stream_if.source  results
);

	localparam int IW         = $clog2(TABLE_WORDS);
	localparam int PB         = (WORD_CHARS > 1) ? $clog2(WORD_CHARS) : 1;
	localparam int CHAR_DEPTH = TABLE_WORDS * (1 << PB);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_LEN  = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t                         state_q;
	state_t                         state_d;
	logic [1:0]                     slot_q;
	logic [1:0]                     slot_d;
	logic [dte_pkg::LEN_W-1:0]      cnt_q;
	logic [dte_pkg::LEN_W-1:0]      cnt_d;
	logic [dte_pkg::LEN_W-1:0]      cnt_nxt;
	logic [dte_pkg::LEN_W-1:0]      len_q;
	dte_pkg::kind_t [2:0]           kinds_q;
	logic [1:0]                     count_q;
	logic [7:0]                     byte_q;
	logic [IW-1:0]                  widx_q;
	logic                           word_ok_q;
	logic [TABLE_WORDS-1:0]         loaded_q;
	logic                           out_valid_q;
	dte_pkg::out_item_t             out_q;
	dte_pkg::out_item_t             out_nxt;
	logic                           out_load;
	logic                           load_ok;
	logic                           accept;
	logic                           tbl_write;
	logic                           stream_beat;
	logic                           write_ok;
	logic                           idx_in_range;
	logic                           plan_store;
	logic                           step_slot;
	logic                           last_slot;
	logic                           last_char;
	dte_pkg::kind_t                 cur_kind;
	dte_pkg::plan_t                 plan;
	dte_pkg::in_item_t              item;

	logic                           len_we;
	logic                           len_re;
	logic [dte_pkg::LEN_W-1:0]      len_wdata;
	logic [dte_pkg::LEN_W-1:0]      len_rdata;
	logic                           char_we;
	logic                           char_re;
	logic [IW+PB-1:0]               char_waddr;
	logic [IW+PB-1:0]               char_raddr;
	logic [7:0]                     char_rdata;

	assign item        = items.payload;
	assign load_ok     = !out_valid_q || results.ready;
	assign items.ready = (state_q == S_IDLE) && load_ok;
	assign accept      = items.valid && items.ready;
	assign tbl_write   = accept && !item.cmd;
	assign stream_beat = accept && item.cmd;

	// table writes outside the configured size are dropped
	assign write_ok     = ({2'b00, item.entry_index} < 9'(TABLE_WORDS)) &&
		({1'b0, item.char_position} < 6'(WORD_CHARS));
	assign idx_in_range = ({1'b0, plan.word_idx} < 9'(TABLE_WORDS));

	dte_scanner u_scanner (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (stream_beat),
		.data_byte  (item.data_byte),
		.stream_end (item.stream_end),
		.plan       (plan)
	);

	// word length store
	assign len_we    = tbl_write && write_ok && item.word_end;
	assign len_wdata = {1'b0, item.char_position} + 6'd1;
	assign len_re    = stream_beat && plan.has_word;

	dte_ram #(
		.WIDTH (dte_pkg::LEN_W),
		.DEPTH (TABLE_WORDS)
	) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (IW'(item.entry_index)),
		.wdata (len_wdata),
		.re    (len_re),
		.raddr (IW'(plan.word_idx)),
		.rdata (len_rdata)
	);

	// word character store, one row of 2**PB characters per word
	assign char_we    = tbl_write && write_ok;
	assign char_waddr = {IW'(item.entry_index), PB'(item.char_position)};
	assign cnt_nxt    = cnt_q + 6'd1;

	dte_ram #(
		.WIDTH (8),
		.DEPTH (CHAR_DEPTH)
	) u_char_ram (
		.clk   (clk),
		.we    (char_we),
		.waddr (char_waddr),
		.wdata (item.data_byte),
		.re    (char_re),
		.raddr (char_raddr),
		.rdata (char_rdata)
	);

	assign cur_kind  = kinds_q[slot_q];
	assign last_slot = (slot_q == (count_q - 2'd1));
	assign last_char = (cnt_nxt == len_q);

	// sequencer: direct emit for single plain results, else slot by slot
	always_comb begin
		state_d    = state_q;
		slot_d     = slot_q;
		cnt_d      = cnt_q;
		out_load   = 1'b0;
		out_nxt    = '{out_byte: 8'd0, bad_reference: 1'b0, last_in_run: 1'b1};
		plan_store = 1'b0;
		step_slot  = 1'b0;
		char_re    = 1'b0;
		char_raddr = {widx_q, PB'(cnt_nxt)};

		unique case (state_q)
			S_IDLE: begin
				if (stream_beat && plan.count != 2'd0) begin
					if (!plan.has_word && plan.count == 2'd1) begin
						out_load         = 1'b1;
						out_nxt.out_byte = (plan.kinds[0] == dte_pkg::KIND_DOLLAR) ?
							dte_pkg::CH_DOLLAR : item.data_byte;
					end else begin
						plan_store = 1'b1;
						slot_d     = 2'd0;
						state_d    = plan.has_word ? S_LEN : S_EMIT;
					end
				end
			end
			S_LEN: begin
				char_re    = 1'b1;
				char_raddr = {widx_q, {PB{1'b0}}};
				cnt_d      = '0;
				state_d    = S_EMIT;
			end
			S_EMIT: begin
				if (load_ok) begin
					out_nxt.last_in_run = last_slot;
					unique case (cur_kind)
						dte_pkg::KIND_DOLLAR: begin
							out_load         = 1'b1;
							out_nxt.out_byte = dte_pkg::CH_DOLLAR;
							step_slot        = 1'b1;
						end
						dte_pkg::KIND_BYTE: begin
							out_load         = 1'b1;
							out_nxt.out_byte = byte_q;
							step_slot        = 1'b1;
						end
						dte_pkg::KIND_WORD: begin
							out_load = 1'b1;
							if (!word_ok_q) begin
								out_nxt.bad_reference = 1'b1;
								step_slot             = 1'b1;
							end else begin
								out_nxt.out_byte    = char_rdata;
								out_nxt.last_in_run = last_slot && last_char;
								char_re             = 1'b1;
								cnt_d               = cnt_nxt;
								step_slot           = last_char;
							end
						end
						dte_pkg::KIND_NONE: begin
							step_slot = 1'b1;
						end
					endcase
					if (step_slot) begin
						cnt_d = '0;
						if (last_slot) begin
							state_d = S_IDLE;
						end else begin
							slot_d = slot_q + 2'd1;
						end
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			slot_q      <= 2'd0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			loaded_q    <= '0;
		end else begin
			state_q <= state_d;
			slot_q  <= slot_d;
			cnt_q   <= cnt_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			if (len_we) begin
				loaded_q[IW'(item.entry_index)] <= 1'b1;
			end
		end
	end

	// plan and payload registers
	always_ff @(posedge clk) begin
		if (plan_store) begin
			kinds_q   <= plan.kinds;
			count_q   <= plan.count;
			byte_q    <= item.data_byte;
			widx_q    <= IW'(plan.word_idx);
			word_ok_q <= !plan.word_ovf && idx_in_range && loaded_q[IW'(plan.word_idx)];
		end
		if (state_q == S_LEN) begin
			len_q <= len_rdata;
		end
		if (out_load) begin
			out_q <= out_nxt;
		end
	end

	assign results.valid   = out_valid_q;
	assign results.payload = out_q;

endmodule

[hdl/dte_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module dte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/dte_scanner.sv]
// token scanner: scan mode and decimal index, plans the results of a stream beat
// depends on dte_pkg
`timescale 1ns / 1ps

module dte_scanner (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic [7:0]      data_byte,
	input  logic            stream_end,
	output dte_pkg::plan_t  plan
);

	dte_pkg::mode_t                 mode_q;
	logic [dte_pkg::ACC_W-1:0]      acc_q;
	dte_pkg::mode_t                 mode_mid;
	dte_pkg::mode_t                 mode_nxt;
	logic [dte_pkg::ACC_W-1:0]      acc_mid;
	logic [dte_pkg::ACC_W-1:0]      acc_nxt;
	logic                           is_digit;
	logic [7:0]                     digit_diff;
	logic [11:0]                    acc_x10;
	logic                           plain_go;
	dte_pkg::kind_t                 pre_kind;
	dte_pkg::kind_t                 mid_kind;
	dte_pkg::kind_t                 post_kind;
	logic [1:0]                     cnt;

	assign is_digit   = (data_byte >= dte_pkg::CH_ZERO) && (data_byte <= dte_pkg::CH_NINE);
	assign digit_diff = data_byte - dte_pkg::CH_ZERO;
	assign acc_x10    = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {8'd0, digit_diff[3:0]};

	// scan step, then optional flush at stream end
	always_comb begin
		mode_mid      = mode_q;
		acc_mid       = acc_q;
		plain_go      = 1'b0;
		pre_kind      = dte_pkg::KIND_NONE;
		mid_kind      = dte_pkg::KIND_NONE;
		post_kind     = dte_pkg::KIND_NONE;
		plan.word_idx = acc_q;
		plan.word_ovf = (mode_q == dte_pkg::MODE_OVERFLOW);

		unique case (mode_q)
			dte_pkg::MODE_DOLLAR: begin
				if (is_digit) begin
					acc_mid  = {4'd0, digit_diff[3:0]};
					mode_mid = dte_pkg::MODE_DIGITS;
				end else begin
					pre_kind = dte_pkg::KIND_DOLLAR;
					plain_go = 1'b1;
				end
			end
			dte_pkg::MODE_DIGITS, dte_pkg::MODE_OVERFLOW: begin
				if (is_digit) begin
					if (mode_q == dte_pkg::MODE_DIGITS) begin
						if (acc_x10 > 12'd255) begin
							mode_mid = dte_pkg::MODE_OVERFLOW;
							acc_mid  = 8'hFF;
						end else begin
							acc_mid = acc_x10[7:0];
						end
					end
				end else begin
					pre_kind = dte_pkg::KIND_WORD;
					plain_go = 1'b1;
				end
			end
			dte_pkg::MODE_PLAIN: begin
				plain_go = 1'b1;
			end
		endcase

		// the byte that ends a token is handled as plain text
		if (plain_go) begin
			if (data_byte == dte_pkg::CH_DOLLAR) begin
				mode_mid = dte_pkg::MODE_DOLLAR;
				acc_mid  = '0;
			end else begin
				mode_mid = dte_pkg::MODE_PLAIN;
				mid_kind = dte_pkg::KIND_BYTE;
			end
		end

		mode_nxt = mode_mid;
		acc_nxt  = acc_mid;
		if (stream_end) begin
			if (mode_mid == dte_pkg::MODE_DOLLAR) begin
				post_kind = dte_pkg::KIND_DOLLAR;
			end else if (mode_mid == dte_pkg::MODE_DIGITS ||
					mode_mid == dte_pkg::MODE_OVERFLOW) begin
				post_kind     = dte_pkg::KIND_WORD;
				plan.word_idx = acc_mid;
				plan.word_ovf = (mode_mid == dte_pkg::MODE_OVERFLOW);
			end
			mode_nxt = dte_pkg::MODE_PLAIN;
			acc_nxt  = '0;
		end

		// pack the non-empty slots in order
		cnt        = 2'd0;
		plan.kinds = {dte_pkg::KIND_NONE, dte_pkg::KIND_NONE, dte_pkg::KIND_NONE};
		if (pre_kind != dte_pkg::KIND_NONE) begin
			plan.kinds[cnt] = pre_kind;
			cnt             = cnt + 2'd1;
		end
		if (mid_kind != dte_pkg::KIND_NONE) begin
			plan.kinds[cnt] = mid_kind;
			cnt             = cnt + 2'd1;
		end
		if (post_kind != dte_pkg::KIND_NONE) begin
			plan.kinds[cnt] = post_kind;
			cnt             = cnt + 2'd1;
		end
		plan.count    = cnt;
		plan.has_word = (pre_kind == dte_pkg::KIND_WORD) || (post_kind == dte_pkg::KIND_WORD);
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= dte_pkg::MODE_PLAIN;
			acc_q  <= '0;
		end else if (step) begin
			mode_q <= mode_nxt;
			acc_q  <= acc_nxt;
		end
	end

endmodule

[hdl/dte_checker.sv]
// port level checker for the dictionary token expander, bound to the top level
// depends on dictionary_token_expander_macros.svh
`timescale 1ns / 1ps
`include "dictionary_token_expander_macros.svh"

module dte_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       bad_reference,
	input logic       last_in_run
);

	// a stalled result beat holds
	`DTE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(bad_reference) && $stable(last_in_run), "result beat changed while stalled")

	// no new item while the current run is unfinished
	`DTE_ASSERT_NOW(a_run_blocks_input, clk, arst_n, out_valid && !last_in_run, !in_ready, "input taken in the middle of a run")

	// a run continues without a gap once it is under way
	`DTE_ASSERT_NEXT(a_run_no_gap, clk, arst_n, out_valid && out_ready && !last_in_run, out_valid, "gap inside a result run")

	// error results carry a zero byte
	`DTE_ASSERT_NOW(a_bad_is_zero, clk, arst_n, out_valid && bad_reference, out_byte == 8'd0, "error result with nonzero byte")

endmodule

bind dictionary_token_expander dte_checker u_dte_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (items.ready),
	.out_valid     (results.valid),
	.out_ready     (results.ready),
	.out_byte      (results.payload.out_byte),
	.bad_reference (results.payload.bad_reference),
	.last_in_run   (results.payload.last_in_run)
);
